/* hdl/itrs_pkg.sv */
`default_nettype none

package itrs_pkg;

    // Field widths
    localparam int VAL_W   = 32;
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 5;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // Alphabet limits
    localparam int MAX_BASE       = 16;
    localparam int STORED_SYMBOLS = 16;
    localparam int EFF_MAX        = (MAX_BASE < STORED_SYMBOLS) ? MAX_BASE : STORED_SYMBOLS;
    localparam int DIGIT_W        = $clog2(STORED_SYMBOLS);
    localparam int SYMS_PER_WORD  = CFG_W / SYM_W;

    // Digit extraction: divide steps retired per cycle
    localparam int STEPS_PER_CYC  = 8;
    localparam int CYC_PER_DIGIT  = VAL_W / STEPS_PER_CYC;
    localparam int STEP_CNT_W     = $clog2(CYC_PER_DIGIT);
    localparam int DIGITS_MAX     = VAL_W;
    localparam int ND_W           = $clog2(DIGITS_MAX + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

    // Character codes
    localparam logic [SYM_W-1:0] CHAR_PLUS      = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS     = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_CTRL_LAST = 8'd31;
    localparam logic [SYM_W-1:0] CHAR_HIGH_MIN  = 8'd128;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [SYM_W-1:0]        t_symbol;

endpackage

`default_nettype wire

/* hdl/itrs_ifs.sv */
`default_nettype none

interface itrs_in_if;
    import itrs_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source(output valid, output value, input ready);
    modport sink(input valid, input value, output ready);
endinterface

interface itrs_out_if;
    import itrs_pkg::*;

    logic    valid;
    logic    ready;
    t_symbol symbol;
    logic    is_last;
    logic    bad_base;

    modport source(output valid, output symbol, output is_last, output bad_base, input ready);
    modport sink(input valid, input symbol, input is_last, input bad_base, output ready);
endinterface

`default_nettype wire

/* hdl/integer_to_radix_string.sv */
`default_nettype none

// Signed 32-bit integer to text in a configurable radix.
//
// Channels: i_in carries one signed value per transfer; o_out carries one
// character per transfer (symbol, is_last, bad_base). A negative value gives
// '-' first, then the digits most significant first; is_last marks the final
// character of each number. An invalid alphabet gives one transfer with
// symbol 0, is_last 1 and bad_base 1.
// Configuration: write base_length (index 0), alphabet_low (1) and
// alphabet_high (2) through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Steps per number: an accept state, an alphabet check over all sixteen
// stored symbols (one symbol against the later ones per cycle), the divider
// (8 restoring steps per cycle) for each digit, then one character out per
// cycle while the receiver takes them. The slowest case is the most
// negative value in binary (sign and 32 digits); the divider loop dominates
// its time.
// A new number is taken once the last character sits in the output register.
// Reset clears the configuration registers to zero, returns the sequencer to
// idle and empties the output register. When the receiver stalls, the output
// register holds and the sequencer waits; no character is lost.

module integer_to_radix_string (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [itrs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [itrs_pkg::CFG_W-1:0]           i_cfg_data,
    itrs_in_if.sink                              i_in,
    itrs_out_if.source                           o_out
);
    import itrs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_BAD   = 3'd5;

    localparam int STK_W = DIGITS_MAX * DIGIT_W;
    localparam logic [LEN_W-1:0] EFF_MAX_L = LEN_W'(EFF_MAX);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [DIGIT_W-1:0] IDX_END = DIGIT_W'(STORED_SYMBOLS - 1);
    localparam logic [STEP_CNT_W-1:0] STEP_END = STEP_CNT_W'(CYC_PER_DIGIT - 1);
    localparam logic [ND_W-1:0] ND_FULL = ND_W'(DIGITS_MAX);
    localparam logic [ND_W-1:0] ND_ONE  = ND_W'(1);

    // Configuration registers
    logic [LEN_W-1:0] r_base_len;
    logic [CFG_W-1:0] r_alpha_lo;
    logic [CFG_W-1:0] r_alpha_hi;

    // Sequencer
    logic [2:0]              r_state, n_state;
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_neg, n_neg;
    logic                    r_bad, n_bad;
    logic [DIGIT_W-1:0]      r_idx, n_idx;
    logic [VAL_W-1:0]        r_mag, n_mag;
    logic [DIGIT_W-1:0]      r_rem, n_rem;
    logic [STEP_CNT_W-1:0]   r_step, n_step;
    logic [ND_W-1:0]         r_nd, n_nd;
    logic [STK_W-1:0]        r_stk, n_stk;

    // Output register
    logic                    r_ov, n_ov;
    t_symbol                 r_osym, n_osym;
    logic                    r_olast, n_olast;
    logic                    r_obad, n_obad;

    logic [2*CFG_W-1:0]      alpha;
    logic [LEN_W-1:0]        eff_len;
    logic [VAL_W-1:0]        raw;
    logic                    out_free;
    t_symbol                 cur_sym;
    logic                    cur_bad;
    logic [LEN_W-1:0]        div_rem;
    logic [VAL_W-1:0]        div_q;
    logic [ND_W-1:0]         nd_inc;

    function automatic t_symbol sym_at(input logic [2*CFG_W-1:0] a,
                                       input logic [DIGIT_W-1:0] k);
        sym_at = a[k*SYM_W +: SYM_W];
    endfunction

    assign alpha    = {r_alpha_hi, r_alpha_lo};
    assign eff_len  = (r_base_len > EFF_MAX_L) ? EFF_MAX_L : r_base_len;
    assign raw      = i_in.value;
    assign out_free = !r_ov || o_out.ready;
    assign nd_inc   = r_nd + ND_ONE;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.symbol   = r_osym;
    assign o_out.is_last  = r_olast;
    assign o_out.bad_base = r_obad;

    // Check one symbol of the alphabet against its range and all later symbols
    always_comb begin
        cur_sym = sym_at(alpha, r_idx);
        cur_bad = (cur_sym == CHAR_PLUS) || (cur_sym == CHAR_MINUS) ||
                  (cur_sym <= CHAR_CTRL_LAST) || (cur_sym >= CHAR_HIGH_MIN);
        for (int j = 0; j < STORED_SYMBOLS; j++) begin
            if ((DIGIT_W'(j) > r_idx) && (LEN_W'(j) < r_len) &&
                (sym_at(alpha, DIGIT_W'(j)) == cur_sym)) begin
                cur_bad = 1'b1;
            end
        end
        cur_bad = cur_bad && ({1'b0, r_idx} < r_len);
    end

    // Restoring division by the radix, several quotient bits per cycle
    always_comb begin
        div_rem = {1'b0, r_rem};
        div_q   = r_mag;
        for (int s = 0; s < STEPS_PER_CYC; s++) begin
            div_rem = {div_rem[LEN_W-2:0], div_q[VAL_W-1]};
            div_q   = {div_q[VAL_W-2:0], 1'b0};
            if (div_rem >= r_len) begin
                div_rem  = div_rem - r_len;
                div_q[0] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_neg   = r_neg;
        n_bad   = r_bad;
        n_idx   = r_idx;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_step  = r_step;
        n_nd    = r_nd;
        n_stk   = r_stk;
        n_ov    = r_ov && !o_out.ready;
        n_osym  = r_osym;
        n_olast = r_olast;
        n_obad  = r_obad;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg   = raw[VAL_W-1];
                    n_mag   = raw[VAL_W-1] ? (VAL_W'(0) - raw) : raw;
                    n_len   = eff_len;
                    n_bad   = eff_len < LEN_MIN;
                    n_idx   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_bad = r_bad || cur_bad;
                n_idx = r_idx + DIGIT_W'(1);
                if (r_idx == IDX_END) begin
                    n_rem   = '0;
                    n_step  = '0;
                    n_nd    = '0;
                    n_state = (r_bad || cur_bad) ? S_BAD : S_DIV;
                end
            end
            S_DIV: begin
                n_mag  = div_q;
                n_rem  = div_rem[DIGIT_W-1:0];
                n_step = r_step + STEP_CNT_W'(1);
                if (r_step == STEP_END) begin
                    // Push the finished digit; restart the remainder
                    n_stk = {r_stk[STK_W-DIGIT_W-1:0], div_rem[DIGIT_W-1:0]};
                    n_nd  = nd_inc;
                    n_rem = '0;
                    if ((div_q == '0) || (nd_inc == ND_FULL)) begin
                        n_state = r_neg ? S_SIGN : S_POP;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_osym  = CHAR_MINUS;
                    n_olast = 1'b0;
                    n_obad  = 1'b0;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_osym  = sym_at(alpha, r_stk[DIGIT_W-1:0]);
                    n_olast = (r_nd == ND_ONE);
                    n_obad  = 1'b0;
                    n_stk   = {{DIGIT_W{1'b0}}, r_stk[STK_W-1:DIGIT_W]};
                    n_nd    = r_nd - ND_ONE;
                    if (r_nd == ND_ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_osym  = '0;
                    n_olast = 1'b1;
                    n_obad  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ov       <= 1'b0;
            r_base_len <= '0;
            r_alpha_lo <= '0;
            r_alpha_hi <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_LENGTH:   r_base_len <= i_cfg_data[LEN_W-1:0];
                    CFG_ALPHABET_LOW:  r_alpha_lo <= i_cfg_data;
                    CFG_ALPHABET_HIGH: r_alpha_hi <= i_cfg_data;
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_neg   <= n_neg;
        r_bad   <= n_bad;
        r_idx   <= n_idx;
        r_mag   <= n_mag;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_nd    <= n_nd;
        r_stk   <= n_stk;
        r_osym  <= n_osym;
        r_olast <= n_olast;
        r_obad  <= n_obad;
    end

`ifndef ASSERT_OFF
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CHECK))
        else $error("accepted item did not start the alphabet check");

    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) || (r_state == S_SIGN) || (r_state == S_POP)) |->
        (r_nd <= ND_FULL))
        else $error("digit count beyond capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_nd != '0))
        else $error("pop from empty digit stack");

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < r_len))
        else $error("partial remainder not below radix");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_obad) |-> (r_olast && (r_osym == '0)))
        else $error("bad alphabet result malformed");
`endif

endmodule

`default_nettype wire

/* bench/tb_integer_to_radix_string.sv */
module tb_integer_to_radix_string;
    import itrs_pkg::*;

    // Index 3 is decoded by nobody; writes there must leave the alphabet alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Ways to spoil an otherwise valid alphabet.
    typedef enum int {
        FLAW_NONE,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_CTRL,
        FLAW_HIGH,
        FLAW_REPEAT,
        FLAW_SHORT
    } flaw_t;

    // One character on the output channel.
    typedef struct packed {
        t_symbol symbol;
        logic    is_last;
        logic    bad_base;
    } text_char_t;

    // Mirrors the three registers and spells every accepted value into the
    // characters the block owes us, oldest first.
    class radix_text_board;
        logic [LEN_W-1:0] base_len;
        logic [CFG_W-1:0] alpha_lo;
        logic [CFG_W-1:0] alpha_hi;
        text_char_t       awaited_chars[$];
        int               seen;

        function new();
            base_len = '0;
            alpha_lo = '0;
            alpha_hi = '0;
            seen     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_BASE_LENGTH:   base_len = data[LEN_W-1:0];
                CFG_ALPHABET_LOW:  alpha_lo = data;
                CFG_ALPHABET_HIGH: alpha_hi = data;
                default: ;
            endcase
        endfunction

        function t_symbol symbol_of(int unsigned k);
            return (k < SYMS_PER_WORD) ? alpha_lo[SYM_W*k +: SYM_W]
                                       : alpha_hi[SYM_W*(k-SYMS_PER_WORD) +: SYM_W];
        endfunction

        function int unsigned radix();
            return (base_len > EFF_MAX) ? EFF_MAX : base_len;
        endfunction

        function bit alphabet_valid(int unsigned n);
            t_symbol c;
            if (n < 2)
                return 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
                c = symbol_of(i);
                if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_CTRL_LAST ||
                    c >= CHAR_HIGH_MIN)
                    return 1'b0;
                for (int unsigned j = i + 1; j < n; j++)
                    if (symbol_of(j) == c)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_value(t_value v);
            int unsigned n;
            logic [VAL_W-1:0] mag;
            logic [DIGIT_W-1:0] digits [DIGITS_MAX];
            int nd;
            n = radix();
            if (!alphabet_valid(n)) begin
                awaited_chars.push_back('{symbol: '0, is_last: 1'b1, bad_base: 1'b1});
                return;
            end
            // Unsigned negate gives the exact magnitude of the most negative value.
            mag = v[VAL_W-1] ? (32'd0 - v) : v;
            nd = 0;
            do begin
                digits[nd] = DIGIT_W'(mag % n);
                nd++;
                mag = mag / n;
            end while (mag != 0 && nd < DIGITS_MAX);
            if (v[VAL_W-1])
                awaited_chars.push_back('{symbol: CHAR_MINUS, is_last: 1'b0, bad_base: 1'b0});
            for (int k = nd - 1; k >= 0; k--)
                awaited_chars.push_back('{symbol: symbol_of(digits[k]), is_last: (k == 0),
                                          bad_base: 1'b0});
        endfunction

        function bit check_char(text_char_t got, output string why);
            text_char_t want;
            seen++;
            if (awaited_chars.size() == 0) begin
                why = $sformatf("character %0d (symbol %h) arrived with nothing awaited",
                                seen, got.symbol);
                return 1'b0;
            end
            want = awaited_chars.pop_front();
            why = "";
            if (got.symbol !== want.symbol)
                why = {why, $sformatf(" symbol %h want %h", got.symbol, want.symbol)};
            if (got.is_last !== want.is_last)
                why = {why, $sformatf(" is_last %b want %b", got.is_last, want.is_last)};
            if (got.bad_base !== want.bad_base)
                why = {why, $sformatf(" bad_base %b want %b", got.bad_base, want.bad_base)};
            if (why.len() == 0)
                return 1'b1;
            why = $sformatf("character %0d:%s", seen, why);
            return 1'b0;
        endfunction

        function int pending();
            return awaited_chars.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    itrs_in_if  in_ch ();
    itrs_out_if out_ch ();

    integer_to_radix_string dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    radix_text_board sb = new();
    int   mismatches = 0;
    logic idling_on = 1'b1;
    int   stall_left = 0;

    always #10 i_clk = ~i_clk;

    // Print the first few mismatches, count them all.
    task report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // Receiver: now and then hold ready low for a random burst while idling is on,
    // otherwise take every character.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            out_ch.ready  <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 19) - 1;
            out_ch.ready  <= 1'b0;
        end else begin
            out_ch.ready  <= 1'b1;
        end
    end

    // Check every output transfer against the oldest awaited character.
    always @(posedge i_clk) begin : watch_text
        text_char_t got;
        string      why;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{symbol: out_ch.symbol, is_last: out_ch.is_last,
                    bad_base: out_ch.bad_base};
            if (!sb.check_char(got, why))
                report_mismatch(why);
        end
    end

    // All driving tasks start and end right at a rising edge.

    // Present one register write; the caller drops the write enable afterwards.
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Load all three registers, optionally poking the undecoded index too.
    task load_alphabet(input logic [LEN_W-1:0] len, input logic [CFG_W-1:0] lo,
                       input logic [CFG_W-1:0] hi, input bit poke_unused);
        write_reg(CFG_BASE_LENGTH, CFG_W'(len));
        write_reg(CFG_ALPHABET_LOW, lo);
        write_reg(CFG_ALPHABET_HIGH, hi);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
    endtask

    // Offer one value, maybe after an idle burst, and hold until the transfer.
    task send_value(input t_value v);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_value(v);
    endtask

    // Drop valid and wait until every awaited character has come back.
    task wait_for_text();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly ordinary integers, with a share of small ones and the extremes.
    function automatic t_value rand_value();
        t_value v;
        case ($urandom_range(0, 7))
            0: case ($urandom_range(0, 4))
                   0: v = 32'sd0;
                   1: v = 32'sd1;
                   2: v = -32'sd1;
                   3: v = t_value'(32'h7FFF_FFFF);
                   default: v = t_value'(32'h8000_0000);
               endcase
            1, 2: begin
                v = t_value'($urandom_range(0, 40));
                if ($urandom_range(0, 1)) v = -v;
            end
            3, 4: begin
                v = t_value'($urandom >> $urandom_range(0, 31));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = t_value'($urandom);
        endcase
        return v;
    endfunction

    // Build distinct printable symbols for the live slots, junk in the rest,
    // then spoil the alphabet as the flaw asks.
    function automatic void make_alphabet(input logic [LEN_W-1:0] len, input flaw_t flaw,
                                          output logic [LEN_W-1:0] len_out,
                                          output logic [CFG_W-1:0] lo,
                                          output logic [CFG_W-1:0] hi);
        t_symbol     syms [STORED_SYMBOLS];
        logic [255:0] used;
        int unsigned n, pos, other;
        t_symbol     c;
        n = (len > EFF_MAX) ? EFF_MAX : len;
        used = '0;
        for (int i = 0; i < STORED_SYMBOLS; i++) begin
            if (i < n) begin
                do c = t_symbol'($urandom_range(32, 127));
                while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
                used[c] = 1'b1;
                syms[i] = c;
            end else begin
                syms[i] = t_symbol'($urandom);
            end
        end
        pos = $urandom_range(0, n - 1);
        other = (pos + $urandom_range(1, n - 1)) % n;
        len_out = len;
        case (flaw)
            FLAW_PLUS:   syms[pos] = CHAR_PLUS;
            FLAW_MINUS:  syms[pos] = CHAR_MINUS;
            FLAW_CTRL:   syms[pos] = t_symbol'($urandom_range(0, CHAR_CTRL_LAST));
            FLAW_HIGH:   syms[pos] = t_symbol'($urandom_range(CHAR_HIGH_MIN, 255));
            FLAW_REPEAT: syms[other] = syms[pos];
            FLAW_SHORT:  len_out = LEN_W'($urandom_range(0, 1));
            default: ;
        endcase
        for (int i = 0; i < STORED_SYMBOLS; i++)
            if (i < SYMS_PER_WORD) lo[SYM_W*i +: SYM_W] = syms[i];
            else hi[SYM_W*(i-SYMS_PER_WORD) +: SYM_W] = syms[i];
    endfunction

    initial begin
        logic [LEN_W-1:0] len;
        logic [CFG_W-1:0] lo, hi;
        flaw_t            flaw;
        int               pause_at;

        // Every input known from time zero; reset asserted first, then released.
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers are still zero after reset: every value is a bad base.
        send_value(32'sd0);
        send_value(-32'sd1);
        wait_for_text();

        // Decimal; also poke the undecoded index, which must change nothing.
        load_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938, 1'b1);
        send_value(32'sd0);
        send_value(32'sd7);
        send_value(-32'sd7);
        send_value(t_value'(32'h7FFF_FFFF));
        send_value(t_value'(32'h8000_0000));
        send_value(32'sd10);
        send_value(-32'sd100);
        wait_for_text();

        // Binary with the edge printable bytes 0x7F and 0x20 as digits; junk
        // above them must be ignored. The most negative value gives 33 transfers.
        load_alphabet(5'd2, 64'hFFFF_FFFF_FFFF_207F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(t_value'(32'h8000_0000));
        send_value(t_value'(32'h7FFF_FFFF));
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        wait_for_text();

        // Largest length code, capped to sixteen symbols: lowercase hex.
        load_alphabet(5'd31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 1'b0);
        send_value(t_value'(32'h8000_0000));
        send_value(32'sd255);
        send_value(t_value'(32'h7FFF_FFFF));
        wait_for_text();

        // One item under each kind of broken alphabet.
        for (int f = FLAW_PLUS; f <= FLAW_SHORT; f++) begin
            make_alphabet(5'd16, flaw_t'(f), len, lo, hi);
            load_alphabet(len, lo, hi, 1'b0);
            send_value(t_value'($urandom));
            wait_for_text();
        end
        load_alphabet(5'd16, '1, '1, 1'b0);
        send_value(t_value'($urandom));
        wait_for_text();
        load_alphabet(5'd0, '1, '1, 1'b0);
        send_value(t_value'($urandom));
        wait_for_text();

        // Random phases: a fresh alphabet each, mostly valid, sometimes spoiled.
        // The last three run without idling on either side.
        for (int r = 0; r < 13; r++) begin
            idling_on <= (r < 10);
            case ($urandom_range(0, 9))
                0: len = 5'd2;
                1: len = 5'd16;
                2: len = LEN_W'($urandom_range(17, 31));
                default: len = LEN_W'($urandom_range(3, 15));
            endcase
            flaw = ($urandom_range(0, 4) == 0) ?
                   flaw_t'($urandom_range(FLAW_PLUS, FLAW_SHORT)) : FLAW_NONE;
            make_alphabet(len, flaw, len, lo, hi);
            load_alphabet(len, lo, hi, $urandom_range(0, 3) == 0);
            // Now and then starve the block mid-phase until it has caught up.
            pause_at = $urandom_range(5, 40);
            for (int i = 0; i < 30; i++) begin
                if (i == pause_at)
                    wait_for_text();
                send_value(rand_value());
            end
            wait_for_text();
        end

        // Give any stray character time to show up before the verdict.
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
